// File: design/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg
// Shared constants, action and event codes, and the controller/datapath
// command and status types of the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

  // store depth and derived sizes
  localparam int unsigned DEPTH       = 256;
  localparam int unsigned STORE_DEPTH = (DEPTH < 256) ? DEPTH : 256;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CAP_W       = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  // action codes
  typedef enum logic [3:0] {
    ACT_OPEN      = 4'd0,
    ACT_INSERT    = 4'd1,
    ACT_LEFT      = 4'd2,
    ACT_RIGHT     = 4'd3,
    ACT_HOME      = 4'd4,
    ACT_END       = 4'd5,
    ACT_DEL_LEFT  = 4'd6,
    ACT_DEL_RIGHT = 4'd7,
    ACT_ENTER     = 4'd8,
    ACT_CANCEL    = 4'd9,
    ACT_READ      = 4'd10
  } action_e;

  // event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTRY = 2'd1,
    EV_TERM  = 2'd2
  } event_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // item transfer, decode and update state
    logic shift;   // tail move in progress
    logic finish;  // close out the item, put the inserted character
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_shift;  // decoded item moves the tail
    logic shift_done;  // all reads issued and all writes retired
  } dp_sts_t;

endpackage

// File: design/leb_ctrl.sv
// ----------------------------------------------------------------------------
// leb_ctrl
// Controller of the line edit buffer: takes items, runs the tail move and
// closes out each item that moves the tail.
// ----------------------------------------------------------------------------
module leb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  leb_pkg::dp_sts_t sts_i,
  output leb_pkg::dp_cmd_t cmd_o,
  output logic            busy_o
);
  import leb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        busy_q, busy_d;

  // commands to the datapath
  always_comb begin
    cmd_o.load   = start_i && !busy_q;
    cmd_o.shift  = (state_q == ST_SHIFT);
    cmd_o.finish = (state_q == ST_SHIFT) && sts_i.shift_done;
  end

  // next state
  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load && sts_i.need_shift) begin
          state_d = ST_SHIFT;
          busy_d  = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (sts_i.shift_done) begin
          state_d = ST_IDLE;
          busy_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  // state and registered busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

  // busy follows the state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q == ST_SHIFT))
    else $error("busy out of step with state");

  // a finished move returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !busy_q)
    else $error("still busy after finish");

  // no transfer is taken during a move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !cmd_o.load)
    else $error("load while busy");

endmodule

// File: design/leb_datapath.sv
// ----------------------------------------------------------------------------
// leb_datapath
// Datapath of the line edit buffer: text store, length, cursor, session flag,
// capacity register, tail move pointers and result registers.
// ----------------------------------------------------------------------------
module leb_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  leb_pkg::dp_cmd_t          cmd_i,
  output leb_pkg::dp_sts_t          sts_o,
  input  logic                      cfg_we_i,
  input  logic [leb_pkg::CAP_W-1:0] cfg_data_i,
  input  logic [3:0]                action_i,
  input  logic [7:0]                char_code_i,
  input  logic [7:0]                index_i,
  output logic                      done_o,
  output logic [1:0]                event_res_o,
  output logic                      active_o,
  output logic [7:0]                cursor_o,
  output logic [7:0]                length_o,
  output logic [7:0]                read_char_o
);
  import leb_pkg::*;

  localparam logic [CAP_W-1:0] STORE_DEPTH_C = CAP_W'(STORE_DEPTH);

  // text store
  logic [7:0] store_q [STORE_DEPTH];

  // architectural state
  logic [CAP_W-1:0] capacity_q;
  logic [7:0]       length_q, cursor_q;
  logic             active_q;

  // result registers
  logic             done_q;
  logic [1:0]       event_q;
  logic             hit_q;
  logic [7:0]       rdata_q;

  // tail move
  logic [7:0]        cnt_q;
  logic              wr_pend_q;
  logic              up_q;
  logic [ADDR_W-1:0] rd_ptr_q, wr_ptr_q, ins_addr_q;
  logic              ins_q;
  logic [7:0]        ch_q;

  // decode results
  logic [CAP_W-1:0] cap_eff, limit;
  logic             dec_shift, dec_ins, dec_up, dec_act, dec_hit;
  logic [7:0]       dec_len, dec_cur, dec_cnt, dec_rd, dec_wr;
  logic [1:0]       dec_evt;

  // memory port controls
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [7:0]        mem_wdata;
  logic              step_rd;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [7:0] v);
    return v[ADDR_W-1:0];
  endfunction

  // text limit from capacity
  always_comb begin
    cap_eff = (capacity_q > STORE_DEPTH_C) ? STORE_DEPTH_C : capacity_q;
    limit   = (cap_eff == '0) ? '0 : cap_eff - CAP_W'(1);
  end

  // item decode against current state
  always_comb begin
    dec_shift = 1'b0;
    dec_ins   = 1'b0;
    dec_up    = 1'b0;
    dec_hit   = 1'b0;
    dec_act   = active_q;
    dec_len   = length_q;
    dec_cur   = cursor_q;
    dec_cnt   = '0;
    dec_rd    = '0;
    dec_wr    = '0;
    dec_evt   = EV_NONE;
    if (action_i == ACT_OPEN) begin
      dec_evt = active_q ? EV_TERM : EV_NONE;
      dec_act = 1'b1;
      dec_cur = length_q;
    end else if (action_i == ACT_READ) begin
      dec_hit = (index_i < length_q);
    end else if (active_q) begin
      case (action_i)
        ACT_INSERT: begin
          if (char_code_i != 8'd0 && {1'b0, length_q} < limit) begin
            dec_shift = 1'b1;
            dec_ins   = 1'b1;
            dec_cnt   = length_q - cursor_q;
            dec_rd    = length_q - 8'd1;
            dec_wr    = length_q;
            dec_len   = length_q + 8'd1;
            dec_cur   = cursor_q + 8'd1;
          end
        end
        ACT_LEFT: begin
          if (cursor_q != 8'd0) dec_cur = cursor_q - 8'd1;
        end
        ACT_RIGHT: begin
          if (cursor_q < length_q) dec_cur = cursor_q + 8'd1;
        end
        ACT_HOME: begin
          dec_cur = 8'd0;
        end
        ACT_END: begin
          dec_cur = length_q;
        end
        ACT_DEL_LEFT: begin
          if (cursor_q != 8'd0) begin
            dec_shift = 1'b1;
            dec_up    = 1'b1;
            dec_cnt   = length_q - cursor_q;
            dec_rd    = cursor_q;
            dec_wr    = cursor_q - 8'd1;
            dec_len   = length_q - 8'd1;
            dec_cur   = cursor_q - 8'd1;
          end
        end
        ACT_DEL_RIGHT: begin
          if (cursor_q < length_q) begin
            dec_shift = 1'b1;
            dec_up    = 1'b1;
            dec_cnt   = length_q - cursor_q - 8'd1;
            dec_rd    = cursor_q + 8'd1;
            dec_wr    = cursor_q;
            dec_len   = length_q - 8'd1;
          end
        end
        ACT_ENTER: begin
          dec_act = 1'b0;
          dec_evt = EV_ENTRY;
        end
        ACT_CANCEL: begin
          dec_act = 1'b0;
          dec_evt = EV_TERM;
        end
        default: begin
        end
      endcase
    end
  end

  // status to the controller
  always_comb begin
    sts_o.need_shift = dec_shift;
    sts_o.shift_done = (cnt_q == 8'd0) && !wr_pend_q;
  end

  // memory port selection
  always_comb begin
    step_rd   = cmd_i.shift && (cnt_q != 8'd0);
    mem_re    = (cmd_i.load && action_i == ACT_READ) || step_rd;
    mem_raddr = cmd_i.load ? to_addr(index_i) : rd_ptr_q;
    if (cmd_i.finish && ins_q) begin
      mem_we    = 1'b1;
      mem_waddr = ins_addr_q;
      mem_wdata = ch_q;
    end else begin
      mem_we    = cmd_i.shift && wr_pend_q;
      mem_waddr = wr_ptr_q;
      mem_wdata = rdata_q;
    end
  end

  // text store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= store_q[mem_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
      length_q   <= '0;
      cursor_q   <= '0;
      active_q   <= 1'b0;
      done_q     <= 1'b0;
      event_q    <= EV_NONE;
      hit_q      <= 1'b0;
      cnt_q      <= '0;
      wr_pend_q  <= 1'b0;
      ins_q      <= 1'b0;
    end else begin
      if (cfg_we_i) capacity_q <= cfg_data_i;
      done_q    <= (cmd_i.load && !dec_shift) || cmd_i.finish;
      wr_pend_q <= step_rd;
      if (cmd_i.load) begin
        length_q <= dec_len;
        cursor_q <= dec_cur;
        active_q <= dec_act;
        event_q  <= dec_evt;
        hit_q    <= dec_hit;
        cnt_q    <= dec_cnt;
        ins_q    <= dec_ins;
      end else if (step_rd) begin
        cnt_q <= cnt_q - 8'd1;
      end
    end
  end

  // move pointers and insert payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_ptr_q   <= to_addr(dec_rd);
      wr_ptr_q   <= to_addr(dec_wr);
      up_q       <= dec_up;
      ins_addr_q <= to_addr(cursor_q);
      ch_q       <= char_code_i;
    end else begin
      if (step_rd) rd_ptr_q <= up_q ? rd_ptr_q + ADDR_W'(1) : rd_ptr_q - ADDR_W'(1);
      if (cmd_i.shift && wr_pend_q) begin
        wr_ptr_q <= up_q ? wr_ptr_q + ADDR_W'(1) : wr_ptr_q - ADDR_W'(1);
      end
    end
  end

  // result ports
  assign done_o      = done_q;
  assign event_res_o = event_q;
  assign active_o    = active_q;
  assign cursor_o    = cursor_q;
  assign length_o    = length_q;
  assign read_char_o = hit_q ? rdata_q : 8'd0;

  // cursor stays within the text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= length_q)
    else $error("cursor beyond text length");

  // text fits the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, length_q} < STORE_DEPTH_C)
    else $error("text length exceeds store");

  // a result is never shown while a move is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !cmd_i.shift)
    else $error("result during tail move");

  // pending writes come only from move reads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> $past(cmd_i.shift))
    else $error("stray pending write");

endmodule

// File: design/line_edit_buffer_unit.sv
// ----------------------------------------------------------------------------
// line_edit_buffer_unit
// Single-line text edit buffer with a cursor, one result per action.
// ----------------------------------------------------------------------------
// usage
//   command channel: drive action_i, char_code_i and index_i with start_i;
//   the transfer happens at a clock edge with start_i high and busy_o low.
//   result channel: done_o is high for exactly one cycle, with event_res_o,
//   active_o, cursor_o, length_o and read_char_o valid in that cycle; the
//   receiver cannot stall, so results must be taken when shown.
//   config channel: cfg_valid_i with cfg_data_i writes the capacity register;
//   cfg_ready_o is always high. write only while no item is in flight.
// result timing and throughput
//   open, cursor moves, enter, cancel, read and dropped edits: done_o in
//   the cycle after the transfer, and a new item may follow every cycle.
//   insert, delete left and delete right raise busy_o for a tail move; no
//   new item is taken while busy_o is high, and done_o follows the move.
//   the tail moves one character per cycle through the single read and
//   single write port of the text store.
// reset
//   text empty, cursor zero, no session open, capacity 256; the store
//   contents are not cleared.
// ----------------------------------------------------------------------------
module line_edit_buffer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [3:0]                action_i,
  input  logic [7:0]                char_code_i,
  input  logic [7:0]                index_i,
  output logic                      done_o,
  output logic [1:0]                event_res_o,
  output logic                      active_o,
  output logic [7:0]                cursor_o,
  output logic [7:0]                length_o,
  output logic [7:0]                read_char_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [leb_pkg::CAP_W-1:0] cfg_data_i
);
  import leb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  // controller
  leb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // datapath
  leb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .action_i    (action_i),
    .char_code_i (char_code_i),
    .index_i     (index_i),
    .done_o      (done_o),
    .event_res_o (event_res_o),
    .active_o    (active_o),
    .cursor_o    (cursor_o),
    .length_o    (length_o),
    .read_char_o (read_char_o)
  );

endmodule
